// ===== rtl/ecfr_pkg.sv =====
// shared types, constants and crc function for the escaped crc frame receiver
package ecfr_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CrcW  = 16;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CrcW-1:0] CrcPoly = 16'h1021;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_START_FLAG  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_END_FLAG    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ESCAPE_BYTE = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_FLIP_MASK   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_NAK_CODE    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_MAX_PAYLOAD = 3'd5;

  localparam logic [ByteW-1:0] START_FLAG_RST  = 8'd2;
  localparam logic [ByteW-1:0] END_FLAG_RST    = 8'd3;
  localparam logic [ByteW-1:0] ESCAPE_BYTE_RST = 8'd27;
  localparam logic [ByteW-1:0] FLIP_MASK_RST   = 8'd32;
  localparam logic [ByteW-1:0] NAK_CODE_RST    = 8'd21;
  localparam logic [ByteW-1:0] MAX_PAYLOAD_RST = 8'd255;

  typedef enum logic [1:0] {
    KIND_RAW  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_ACK  = 2'd2,
    KIND_NAK  = 2'd3
  } kind_e;

  typedef enum logic [6:0] {
    PH_IDLE = 7'b0000001,
    PH_CMD  = 7'b0000010,
    PH_LEN  = 7'b0000100,
    PH_DATA = 7'b0001000,
    PH_CRCH = 7'b0010000,
    PH_CRCL = 7'b0100000,
    PH_END  = 7'b1000000
  } phase_e;

  // crc-16/xmodem update by one byte, msb first
  function automatic logic [CrcW-1:0] crc_feed(input logic [CrcW-1:0] crc,
                                               input logic [ByteW-1:0] b);
    logic [CrcW-1:0] r;
    r = crc ^ {b, 8'h00};
    for (int k = 0; k < ByteW; k++) begin
      if (r[CrcW-1]) begin
        r = {r[CrcW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        r = {r[CrcW-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/escaped_crc_frame_receiver.sv =====
// byte-stuffed frame receiver with crc-16/xmodem check
// an accepted byte passes through the input register and then the result register
// throughput: one byte per cycle while the result is not stalled; the phase, unstuffing and
//   crc update of a byte sit in one combinational step between the input and result registers
// reset: asynchronous, active low; back to idle with the flags at their default values
module escaped_crc_frame_receiver (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ecfr_pkg::ByteW-1:0]    rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    result_kind_o,
  output logic [ecfr_pkg::ByteW-1:0]    result_byte_o,
  output logic [ecfr_pkg::ByteW-1:0]    payload_index_o,
  output logic [ecfr_pkg::ByteW-1:0]    frame_cmd_o,
  output logic [ecfr_pkg::ByteW-1:0]    frame_len_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ecfr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ecfr_pkg::ByteW-1:0]    cfg_data_i
);
  import ecfr_pkg::*;

  // configuration
  logic [ByteW-1:0] start_flag_q, end_flag_q, escape_byte_q;
  logic [ByteW-1:0] flip_mask_q, nak_code_q, max_payload_q;

  // input register
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;

  // frame state
  phase_e           phase_q, phase_d;
  logic             esc_q, esc_d;
  logic [ByteW-1:0] cmd_q, cmd_d;
  logic [ByteW-1:0] len_q, len_d;
  logic [ByteW-1:0] count_q, count_d;
  logic [CrcW-1:0]  rx_crc_q, rx_crc_d;
  logic [CrcW-1:0]  run_crc_q, run_crc_d;

  // result register
  logic             out_valid_q;
  kind_e            out_kind_q;
  logic [ByteW-1:0] out_byte_q, out_idx_q, out_cmd_q, out_len_q;

  // result of the byte in the input register
  logic             res_valid;
  kind_e            res_kind;
  logic [ByteW-1:0] res_byte, res_idx, res_cmd, res_len;

  logic             advance;
  logic             process;
  logic             in_accept;
  logic [ByteW-1:0] b;
  logic [ByteW-1:0] d;
  logic             have_data;
  logic [ByteW-1:0] count_inc;
  logic [CrcW-1:0]  crc_next;

  assign advance   = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept = in_valid_i && !in_stall_o;
  assign process   = in_valid_q && advance;
  assign cfg_ready_o = 1'b1;

  assign b         = in_byte_q;
  assign count_inc = count_q + 8'd1;

  // unstuffing of the bytes between the flags
  always_comb begin
    d         = b;
    have_data = 1'b0;
    if (esc_q) begin
      d         = b ^ flip_mask_q;
      have_data = 1'b1;
    end else if (b != end_flag_q && b != escape_byte_q) begin
      have_data = 1'b1;
    end
  end

  assign crc_next = crc_feed(run_crc_q, d);

  always_comb begin
    phase_d   = phase_q;
    esc_d     = esc_q;
    cmd_d     = cmd_q;
    len_d     = len_q;
    count_d   = count_q;
    rx_crc_d  = rx_crc_q;
    run_crc_d = run_crc_q;
    res_valid = 1'b0;
    res_kind  = KIND_RAW;
    res_byte  = '0;
    res_idx   = '0;
    res_cmd   = '0;
    res_len   = '0;
    if (process) begin
      unique case (phase_q)
        PH_IDLE: begin
          if (b != start_flag_q) begin
            res_valid = 1'b1;
            res_kind  = KIND_RAW;
            res_byte  = b;
          end else begin
            phase_d   = PH_CMD;
            esc_d     = 1'b0;
            cmd_d     = '0;
            len_d     = '0;
            count_d   = '0;
            rx_crc_d  = '0;
            run_crc_d = '0;
          end
        end
        PH_END: begin
          // closing byte is taken raw
          res_valid = 1'b1;
          phase_d   = PH_IDLE;
          res_len   = len_q;
          if (b != end_flag_q || rx_crc_q != run_crc_q) begin
            res_kind = KIND_NAK;
            res_cmd  = nak_code_q;
            esc_d    = 1'b0;
          end else begin
            res_kind = KIND_ACK;
            res_cmd  = cmd_q;
          end
        end
        default: begin
          if (esc_q) begin
            esc_d = 1'b0;
          end else if (b == end_flag_q) begin
            // unescaped end flag inside the frame
            res_valid = 1'b1;
            res_kind  = KIND_NAK;
            res_cmd   = nak_code_q;
            res_len   = len_q;
            phase_d   = PH_IDLE;
          end else if (b == escape_byte_q) begin
            esc_d = 1'b1;
          end
          if (have_data) begin
            unique case (phase_q)
              PH_CMD: begin
                cmd_d     = d;
                run_crc_d = crc_next;
                phase_d   = PH_LEN;
              end
              PH_LEN: begin
                len_d     = d;
                run_crc_d = crc_next;
                count_d   = '0;
                if (d > max_payload_q) begin
                  res_valid = 1'b1;
                  res_kind  = KIND_NAK;
                  res_cmd   = nak_code_q;
                  res_len   = d;
                  phase_d   = PH_IDLE;
                  esc_d     = 1'b0;
                end else if (d == '0) begin
                  phase_d = PH_CRCH;
                end else begin
                  phase_d = PH_DATA;
                end
              end
              PH_DATA: begin
                run_crc_d = crc_next;
                res_valid = 1'b1;
                res_kind  = KIND_DATA;
                res_byte  = d;
                res_idx   = count_q;
                res_cmd   = cmd_q;
                res_len   = len_q;
                count_d   = count_inc;
                if (count_inc >= len_q) begin
                  phase_d = PH_CRCH;
                end
              end
              PH_CRCH: begin
                rx_crc_d = {d, 8'h00};
                phase_d  = PH_CRCL;
              end
              PH_CRCL: begin
                rx_crc_d = {rx_crc_q[CrcW-1:ByteW], d};
                phase_d  = PH_END;
              end
              default: begin
                phase_d = PH_IDLE;
              end
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_flag_q  <= START_FLAG_RST;
      end_flag_q    <= END_FLAG_RST;
      escape_byte_q <= ESCAPE_BYTE_RST;
      flip_mask_q   <= FLIP_MASK_RST;
      nak_code_q    <= NAK_CODE_RST;
      max_payload_q <= MAX_PAYLOAD_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_START_FLAG:  start_flag_q  <= cfg_data_i;
        CFG_END_FLAG:    end_flag_q    <= cfg_data_i;
        CFG_ESCAPE_BYTE: escape_byte_q <= cfg_data_i;
        CFG_FLIP_MASK:   flip_mask_q   <= cfg_data_i;
        CFG_NAK_CODE:    nak_code_q    <= cfg_data_i;
        CFG_MAX_PAYLOAD: max_payload_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      phase_q     <= PH_IDLE;
      esc_q       <= 1'b0;
      cmd_q       <= '0;
      len_q       <= '0;
      count_q     <= '0;
      rx_crc_q    <= '0;
      run_crc_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      phase_q   <= phase_d;
      esc_q     <= esc_d;
      cmd_q     <= cmd_d;
      len_q     <= len_d;
      count_q   <= count_d;
      rx_crc_q  <= rx_crc_d;
      run_crc_q <= run_crc_d;
      if (advance) begin
        out_valid_q <= res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= rx_byte_i;
    end
    if (advance && res_valid) begin
      out_kind_q <= res_kind;
      out_byte_q <= res_byte;
      out_idx_q  <= res_idx;
      out_cmd_q  <= res_cmd;
      out_len_q  <= res_len;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = out_kind_q;
  assign result_byte_o   = out_byte_q;
  assign payload_index_o = out_idx_q;
  assign frame_cmd_o     = out_cmd_q;
  assign frame_len_o     = out_len_q;

endmodule

// ===== rtl/ecfr_checker.sv =====
// port-level assertions for the escaped crc frame receiver, bound to the top level
module ecfr_assert (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [1:0]                    result_kind_o,
  input logic [ecfr_pkg::ByteW-1:0]    result_byte_o,
  input logic [ecfr_pkg::ByteW-1:0]    payload_index_o,
  input logic [ecfr_pkg::ByteW-1:0]    frame_cmd_o,
  input logic [ecfr_pkg::ByteW-1:0]    frame_len_o
);
  import ecfr_pkg::*;

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_kind_o)
      && $stable(result_byte_o) && $stable(payload_index_o)
      && $stable(frame_cmd_o) && $stable(frame_len_o))
    else $error("result changed while stalled");

  // input back-pressure only comes from a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  // a new result follows an accepted request
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a request");

  // raw bytes and verdicts carry zeros in the unused fields
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o != KIND_DATA |-> payload_index_o == '0
      && ((result_kind_o == KIND_RAW && frame_cmd_o == '0 && frame_len_o == '0)
        || (result_kind_o != KIND_RAW && result_byte_o == '0)))
    else $error("unused result field not zero");

endmodule

bind escaped_crc_frame_receiver ecfr_assert u_ecfr_assert (.*);

// ===== tb/ecfr_checker.sv =====
// request monitor, frame decode predictor and result scoreboard for the frame receiver
`timescale 1ns / 100ps

module ecfr_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [ecfr_pkg::ByteW-1:0]    rx_byte_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [1:0]                    result_kind_i,
  input  logic [ecfr_pkg::ByteW-1:0]    result_byte_i,
  input  logic [ecfr_pkg::ByteW-1:0]    payload_index_i,
  input  logic [ecfr_pkg::ByteW-1:0]    frame_cmd_i,
  input  logic [ecfr_pkg::ByteW-1:0]    frame_len_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [ecfr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ecfr_pkg::ByteW-1:0]    cfg_data_i,
  output int                            error_count_o,
  output int                            outstanding_o
);
  import ecfr_pkg::*;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] data;
    logic [ByteW-1:0] pos;
    logic [ByteW-1:0] cmd;
    logic [ByteW-1:0] len;
  } rx_result_t;

  rx_result_t expected_q[$];

  logic [ByteW-1:0] sof_code, eof_code, esc_code, flip_code, nak_code, max_len;

  phase_e           rx_phase;
  logic             esc_pending;
  logic [ByteW-1:0] cmd_reg, len_reg, data_count;
  logic [CrcW-1:0]  crc_rx, crc_calc;

  function automatic logic [CrcW-1:0] crc_xmodem_step(input logic [CrcW-1:0] crc,
                                                      input logic [ByteW-1:0] d);
    logic [CrcW-1:0] c;
    logic            fb;
    int              i;
    c = crc;
    for (i = ByteW - 1; i >= 0; i--) begin
      fb = c[CrcW-1] ^ d[i];
      c  = {c[CrcW-2:0], 1'b0};
      if (fb) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count_o++;
  endtask

  task automatic compare_field(input string name, input logic [ByteW-1:0] got,
                               input logic [ByteW-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%02h want 0x%02h", name, got, want));
    end
  endtask

  task automatic post_result(input kind_e kind, input logic [ByteW-1:0] data,
                             input logic [ByteW-1:0] pos, input logic [ByteW-1:0] cmd,
                             input logic [ByteW-1:0] len);
    rx_result_t r;
    r.kind = kind;
    r.data = data;
    r.pos  = pos;
    r.cmd  = cmd;
    r.len  = len;
    expected_q.push_back(r);
  endtask

  task automatic post_reject();
    post_result(KIND_NAK, '0, '0, nak_code, len_reg);
    rx_phase    = PH_IDLE;
    esc_pending = 1'b0;
  endtask

  task automatic decode_byte(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] d;
    if (rx_phase == PH_IDLE) begin
      if (b != sof_code) begin
        post_result(KIND_RAW, b, '0, '0, '0);
      end else begin
        rx_phase    = PH_CMD;
        esc_pending = 1'b0;
        cmd_reg     = '0;
        len_reg     = '0;
        data_count  = '0;
        crc_rx      = '0;
        crc_calc    = '0;
      end
    end else if (rx_phase == PH_END) begin
      // closing byte is taken raw
      if (b != eof_code || crc_rx != crc_calc) begin
        post_reject();
      end else begin
        post_result(KIND_ACK, '0, '0, cmd_reg, len_reg);
        rx_phase = PH_IDLE;
      end
    end else if (!esc_pending && b == eof_code) begin
      // end flag test wins over the escape test
      post_reject();
    end else if (!esc_pending && b == esc_code) begin
      esc_pending = 1'b1;
    end else begin
      d           = esc_pending ? (b ^ flip_code) : b;
      esc_pending = 1'b0;
      case (rx_phase)
        PH_CMD: begin
          cmd_reg  = d;
          crc_calc = crc_xmodem_step(crc_calc, d);
          rx_phase = PH_LEN;
        end
        PH_LEN: begin
          len_reg  = d;
          crc_calc = crc_xmodem_step(crc_calc, d);
          if (d > max_len) begin
            post_reject();
          end else begin
            data_count = '0;
            rx_phase   = (d == '0) ? PH_CRCH : PH_DATA;
          end
        end
        PH_DATA: begin
          crc_calc = crc_xmodem_step(crc_calc, d);
          post_result(KIND_DATA, d, data_count, cmd_reg, len_reg);
          data_count = data_count + 1'b1;
          if (data_count >= len_reg) begin
            rx_phase = PH_CRCH;
          end
        end
        PH_CRCH: begin
          crc_rx   = {d, 8'h00};
          rx_phase = PH_CRCL;
        end
        default: begin
          crc_rx[ByteW-1:0] = d;
          rx_phase          = PH_END;
        end
      endcase
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    rx_result_t want;
    if (!rst_ni) begin
      sof_code      = START_FLAG_RST;
      eof_code      = END_FLAG_RST;
      esc_code      = ESCAPE_BYTE_RST;
      flip_code     = FLIP_MASK_RST;
      nak_code      = NAK_CODE_RST;
      max_len       = MAX_PAYLOAD_RST;
      rx_phase      = PH_IDLE;
      esc_pending   = 1'b0;
      cmd_reg       = '0;
      len_reg       = '0;
      data_count    = '0;
      crc_rx        = '0;
      crc_calc      = '0;
      expected_q.delete();
      error_count_o = 0;
      outstanding_o = 0;
    end else begin
      if (out_valid_i === 1'b1 && out_stall_i === 1'b0) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d byte 0x%02h",
                                    result_kind_i, result_byte_i));
        end else begin
          want = expected_q.pop_front();
          compare_field("result_kind", {6'b0, result_kind_i}, {6'b0, want.kind});
          compare_field("result_byte", result_byte_i, want.data);
          compare_field("payload_index", payload_index_i, want.pos);
          compare_field("frame_cmd", frame_cmd_i, want.cmd);
          compare_field("frame_len", frame_len_i, want.len);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_START_FLAG:  sof_code  = cfg_data_i;
          CFG_END_FLAG:    eof_code  = cfg_data_i;
          CFG_ESCAPE_BYTE: esc_code  = cfg_data_i;
          CFG_FLIP_MASK:   flip_code = cfg_data_i;
          CFG_NAK_CODE:    nak_code  = cfg_data_i;
          CFG_MAX_PAYLOAD: max_len   = cfg_data_i;
          default: ;
        endcase
      end
      // one request per accepted rx byte
      if (in_valid_i && !in_stall_i) begin
        decode_byte(rx_byte_i);
      end
      outstanding_o = expected_q.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
// top of the frame receiver testbench: clock, reset, frame stimulus and verdict
`timescale 1ns / 100ps

module tb;
  import ecfr_pkg::*;

  typedef enum int {
    FL_NONE,
    FL_BAD_CRC,
    FL_BAD_CLOSE,
    FL_EARLY_END,
    FL_BIG_LEN,
    FL_CUT
  } frame_flaw_e;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [ByteW-1:0]   rx_byte = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         result_kind;
  logic [ByteW-1:0]   result_byte, payload_index, frame_cmd, frame_len;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = CFG_START_FLAG;
  logic [ByteW-1:0]   cfg_data = '0;
  int                 errors, outstanding;

  // local copy of the settings needed to build frames
  logic [ByteW-1:0] sof_code  = START_FLAG_RST;
  logic [ByteW-1:0] eof_code  = END_FLAG_RST;
  logic [ByteW-1:0] esc_code  = ESCAPE_BYTE_RST;
  logic [ByteW-1:0] flip_code = FLIP_MASK_RST;
  logic [ByteW-1:0] max_len   = MAX_PAYLOAD_RST;

  logic [ByteW-1:0] frame_data[$];
  logic [ByteW-1:0] line_q[$];
  int               sent_bytes = 0;
  int               send_gap_pct = 8;
  int               sink_stall_pct = 47;

  escaped_crc_frame_receiver DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .rx_byte_i       (rx_byte),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .result_kind_o   (result_kind),
    .result_byte_o   (result_byte),
    .payload_index_o (payload_index),
    .frame_cmd_o     (frame_cmd),
    .frame_len_o     (frame_len),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  ecfr_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .rx_byte_i       (rx_byte),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .result_kind_i   (result_kind),
    .result_byte_i   (result_byte),
    .payload_index_i (payload_index),
    .frame_cmd_i     (frame_cmd),
    .frame_len_i     (frame_len),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .error_count_o   (errors),
    .outstanding_o   (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  task automatic push_byte(input logic [ByteW-1:0] b);
    if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_gap_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_bytes++;
  endtask

  // pause the sender until every pending result is out, then let the pipe settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_START_FLAG:  sof_code  = val;
      CFG_END_FLAG:    eof_code  = val;
      CFG_ESCAPE_BYTE: esc_code  = val;
      CFG_FLIP_MASK:   flip_code = val;
      CFG_MAX_PAYLOAD: max_len   = val;
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [ByteW-1:0] sof, input logic [ByteW-1:0] eof,
                               input logic [ByteW-1:0] esc, input logic [ByteW-1:0] flip,
                               input logic [ByteW-1:0] nak, input logic [ByteW-1:0] maxl);
    write_reg(CFG_START_FLAG, sof);
    write_reg(CFG_END_FLAG, eof);
    write_reg(CFG_ESCAPE_BYTE, esc);
    write_reg(CFG_FLIP_MASK, flip);
    write_reg(CFG_NAK_CODE, nak);
    write_reg(CFG_MAX_PAYLOAD, maxl);
    cfg_valid <= 1'b0;
  endtask

  // bias toward the flag and escape values so stuffing gets exercised
  function automatic logic [ByteW-1:0] pick_byte();
    case ($urandom_range(7))
      0: return sof_code;
      1: return eof_code;
      2: return esc_code;
      3: return $urandom_range(1) ? 8'hFF : 8'h00;
      default: return ByteW'($urandom);
    endcase
  endfunction

  function automatic int pick_len();
    if ($urandom_range(99) == 0) begin
      return int'(max_len);
    end
    return $urandom_range(max_len < 12 ? max_len : 12, 0);
  endfunction

  task automatic fill_payload(input int n);
    frame_data.delete();
    repeat (n) frame_data.push_back(pick_byte());
  endtask

  task automatic stuff_byte(input logic [ByteW-1:0] d);
    if (d == eof_code || d == esc_code || $urandom_range(7) == 0) begin
      line_q.push_back(esc_code);
      line_q.push_back(d ^ flip_code);
    end else begin
      line_q.push_back(d);
    end
  endtask

  task automatic send_frame(input logic [ByteW-1:0] cmd, input frame_flaw_e flaw);
    logic [CrcW-1:0]  crc;
    logic [ByteW-1:0] len;
    logic [ByteW-1:0] closing;
    int               cut;
    line_q.delete();
    if (flaw == FL_BIG_LEN && max_len == 8'hFF) begin
      flaw = FL_BAD_CRC;
    end
    len = ByteW'(frame_data.size());
    if (flaw == FL_BIG_LEN) begin
      len = ByteW'($urandom_range(255, max_len + 1));
    end
    crc = '0;
    crc = crc_feed(crc, cmd);
    crc = crc_feed(crc, len);
    foreach (frame_data[i]) crc = crc_feed(crc, frame_data[i]);
    if (flaw == FL_BAD_CRC) begin
      crc = crc ^ (16'h0001 << $urandom_range(15));
    end
    line_q.push_back(sof_code);
    stuff_byte(cmd);
    stuff_byte(len);
    if (flaw != FL_BIG_LEN) begin
      foreach (frame_data[i]) stuff_byte(frame_data[i]);
      stuff_byte(crc[15:8]);
      stuff_byte(crc[7:0]);
      closing = eof_code;
      if (flaw == FL_BAD_CLOSE) begin
        closing = eof_code ^ ByteW'($urandom_range(255, 1));
      end
      line_q.push_back(closing);
    end
    if (flaw == FL_EARLY_END) begin
      cut = $urandom_range(line_q.size() - 1, 1);
      while (line_q.size() > cut) void'(line_q.pop_back());
      line_q.push_back(eof_code);
    end
    if (flaw == FL_CUT) begin
      line_q.delete($urandom_range(line_q.size() - 1, 1));
    end
    foreach (line_q[i]) push_byte(line_q[i]);
  endtask

  initial begin
    int          seg_end;
    int          pick;
    frame_flaw_e flaw;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: raw extremes, zero length with start flag as command,
    // escaped end flag and escape byte as payload, then early end, bad crc and bad close rejects
    push_byte(8'h00);
    push_byte(8'hFF);
    frame_data.delete();
    send_frame(sof_code, FL_NONE);
    frame_data.delete();
    frame_data.push_back(eof_code);
    frame_data.push_back(esc_code);
    send_frame(8'hFF, FL_NONE);
    frame_data.delete();
    send_frame(8'h00, FL_EARLY_END);
    send_frame(8'h5A, FL_BAD_CRC);
    send_frame(8'hA5, FL_BAD_CLOSE);

    for (int seg = 0; seg < 6; seg++) begin
      wait_idle();
      if (seg < 2) begin
        send_gap_pct   = 8;
        sink_stall_pct = 47;
      end else if (seg < 4) begin
        send_gap_pct   = 47;
        sink_stall_pct = 8;
      end else begin
        send_gap_pct   = 0;
        sink_stall_pct = 0;
      end
      case (seg)
        1: load_settings(8'h00, 8'hFF, 8'h7D, 8'h20, 8'h00, 8'h00);
        2: load_settings(8'hFF, 8'h00, 8'hFE, 8'hFF, 8'hFF, 8'hFF);
        // end flag equal to the escape byte, identity flip
        3: load_settings(8'h7E, 8'h55, 8'h55, 8'h00, 8'h80, 8'h08);
        4, 5: load_settings(ByteW'($urandom), ByteW'($urandom), ByteW'($urandom),
                            ByteW'($urandom), ByteW'($urandom), ByteW'($urandom));
        default: ;
      endcase
      seg_end = sent_bytes + 285;
      while (sent_bytes < seg_end) begin
        pick = $urandom_range(99);
        if (pick < 10) begin
          repeat ($urandom_range(3, 1)) push_byte(ByteW'($urandom));
        end else if (pick < 12) begin
          wait_idle();
        end else if (pick < 75) begin
          fill_payload(pick_len());
          send_frame(pick_byte(), FL_NONE);
        end else begin
          flaw = frame_flaw_e'($urandom_range(5, 1));
          fill_payload(pick_len());
          send_frame(pick_byte(), flaw);
        end
      end
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
